### sv/tile_map_collision_resolver_macros.svh
// Assertion macros shared by the tile map collision resolver RTL.
`ifndef TILE_MAP_COLLISION_RESOLVER_MACROS_SVH
`define TILE_MAP_COLLISION_RESOLVER_MACROS_SVH
`ifndef SYNTHESIS
`define TMCR_ASSERT_NOW(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("tmcr assertion failed");
`define TMCR_ASSERT_NEXT(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("tmcr assertion failed");
`else
`define TMCR_ASSERT_NOW(lbl, pre, post)
`define TMCR_ASSERT_NEXT(lbl, pre, post)
`endif
`endif

### sv/tmcr_pkg.sv
// Shared types and constants of the tile map collision resolver.
package tmcr_pkg;
	localparam int TileFix = 64 * 16;
	localparam int HalfTileFix = TileFix / 2;
	localparam int RadiusFix = 30 * 16;
	localparam int SpriteFix = 60 * 16;
	localparam int MinDistFix = RadiusFix + HalfTileFix;
	localparam logic [6:0] MaxCols = 7'd64;
	localparam logic [6:0] MaxRows = 7'd64;

	typedef enum logic {
		OP_WRITE   = 1'b0,
		OP_RESOLVE = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		REG_MAP_WIDTH  = 2'd0,
		REG_MAP_HEIGHT = 2'd1
	} cfg_reg_t;

	// one resolve item in flight through the push stages
	typedef struct packed {
		logic               vld;
		logic               any;
		logic signed [20:0] px;
		logic signed [20:0] py;
		logic [3:0]         hit;
		logic [3:0][5:0]    col;
		logic [3:0][5:0]    row;
	} pipe_t;
endpackage

### sv/tmcr_lookup.sv
// Input stage, tile map store and corner lookup of the collision resolver.
module tmcr_lookup (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                in_valid,
	input  logic                operation,
	input  logic [5:0]          cell_col,
	input  logic [5:0]          cell_row,
	input  logic                cell_solid,
	input  logic signed [17:0]  pos_x,
	input  logic signed [17:0]  pos_y,
	input  logic [6:0]          col_bound,
	input  logic [6:0]          row_bound,
	output tmcr_pkg::pipe_t     out
);
	logic               vld_s1, op_s1, solid_s1;
	logic [5:0]         ccol_s1, crow_s1;
	logic signed [17:0] x_s1, y_s1;
	logic signed [18:0] x0, x1, y0, y1;
	logic [8:0]         c0, c1, r0, r1;
	logic [3:0]         ok;

	logic [63:0] map_mem [64];
	logic [63:0] row_vld_q;

	logic               vld_s2, rv0_s2, rv1_s2;
	logic [63:0]        row0_s2, row1_s2;
	logic [5:0]         c0_s2, c1_s2, r0_s2, r1_s2;
	logic [3:0]         ok_s2;
	logic signed [17:0] x_s2, y_s2;
	logic               wr_en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			op_s1    <= operation;
			ccol_s1  <= cell_col;
			crow_s1  <= cell_row;
			solid_s1 <= cell_solid;
			x_s1     <= pos_x;
			y_s1     <= pos_y;
		end
	end

	always_comb begin
		x0 = 19'(x_s1);
		y0 = 19'(y_s1);
		x1 = x0 + 19'(tmcr_pkg::SpriteFix);
		y1 = y0 + 19'(tmcr_pkg::SpriteFix);
		c0 = x0[18:10];
		c1 = x1[18:10];
		r0 = y0[18:10];
		r1 = y1[18:10];
		ok[0] = !c0[8] && (c0[7:0] < {1'b0, col_bound}) && !r0[8] && (r0[7:0] < {1'b0, row_bound});
		ok[1] = !c1[8] && (c1[7:0] < {1'b0, col_bound}) && !r0[8] && (r0[7:0] < {1'b0, row_bound});
		ok[2] = !c0[8] && (c0[7:0] < {1'b0, col_bound}) && !r1[8] && (r1[7:0] < {1'b0, row_bound});
		ok[3] = !c1[8] && (c1[7:0] < {1'b0, col_bound}) && !r1[8] && (r1[7:0] < {1'b0, row_bound});
	end

	assign wr_en = en && vld_s1 && (op_s1 == tmcr_pkg::OP_WRITE);

	// first write to a row fills the whole row, later ones touch one bit
	always_ff @(posedge clk) begin
		if (wr_en) begin
			if (!row_vld_q[crow_s1]) begin
				map_mem[crow_s1] <= solid_s1 ? (64'd1 << ccol_s1) : 64'd0;
			end else begin
				map_mem[crow_s1][ccol_s1] <= solid_s1;
			end
		end
		if (en) begin
			row0_s2 <= map_mem[r0[5:0]];
			row1_s2 <= map_mem[r1[5:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_vld_q <= '0;
			vld_s2    <= 1'b0;
		end else begin
			if (wr_en) begin
				row_vld_q[crow_s1] <= 1'b1;
			end
			if (en) begin
				vld_s2 <= vld_s1 && (op_s1 == tmcr_pkg::OP_RESOLVE);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rv0_s2 <= row_vld_q[r0[5:0]];
			rv1_s2 <= row_vld_q[r1[5:0]];
			c0_s2  <= c0[5:0];
			c1_s2  <= c1[5:0];
			r0_s2  <= r0[5:0];
			r1_s2  <= r1[5:0];
			ok_s2  <= ok;
			x_s2   <= x_s1;
			y_s2   <= y_s1;
		end
	end

	always_comb begin
		out.vld    = vld_s2;
		out.px     = 21'(x_s2);
		out.py     = 21'(y_s2);
		out.hit[0] = ok_s2[0] && rv0_s2 && row0_s2[c0_s2];
		out.hit[1] = ok_s2[1] && rv0_s2 && row0_s2[c1_s2];
		out.hit[2] = ok_s2[2] && rv1_s2 && row1_s2[c0_s2];
		out.hit[3] = ok_s2[3] && rv1_s2 && row1_s2[c1_s2];
		out.any    = |out.hit;
		out.col    = {c1_s2, c0_s2, c1_s2, c0_s2};
		out.row    = {r1_s2, r1_s2, r0_s2, r0_s2};
	end
endmodule

### sv/tmcr_push_stage.sv
// One push-out stage: resolves the corner at the head of the list, then shifts it off.
module tmcr_push_stage (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  tmcr_pkg::pipe_t in,
	output tmcr_pkg::pipe_t out
);
	logic signed [22:0] px, py, tx, ty, dx, dy, adx, ady, xd, yd, mx, my;
	logic signed [22:0] nx, ny;
	tmcr_pkg::pipe_t    nxt, st_s;

	always_comb begin
		px  = 23'(in.px);
		py  = 23'(in.py);
		tx  = $signed({7'd0, in.col[0], 10'h200});
		ty  = $signed({7'd0, in.row[0], 10'h200});
		dx  = px + 23'(tmcr_pkg::RadiusFix) - tx;
		dy  = py + 23'(tmcr_pkg::RadiusFix) - ty;
		adx = dx[22] ? -dx : dx;
		ady = dy[22] ? -dy : dy;
		xd  = 23'(tmcr_pkg::MinDistFix) - adx;
		yd  = 23'(tmcr_pkg::MinDistFix) - ady;
		mx  = (xd > 0) ? xd : '0;
		my  = (yd > 0) ? yd : '0;
		nx  = px;
		ny  = py;
		if (in.hit[0] && ((xd > 0) || (yd > 0))) begin
			if (mx < my) begin
				nx = dx[22] ? px - xd : px + xd;
			end else begin
				ny = dy[22] ? py - yd : py + yd;
			end
		end
		nxt     = in;
		nxt.px  = nx[20:0];
		nxt.py  = ny[20:0];
		nxt.hit = in.hit >> 1;
		nxt.col = in.col >> 6;
		nxt.row = in.row >> 6;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_s <= '0;
		end else if (en) begin
			st_s <= nxt;
		end
	end

	assign out = st_s;
endmodule

### sv/tile_map_collision_resolver.sv
// Top level of the tile map collision resolver.
// Use: the input channel (in_valid / in_stall) carries one beat per item. A beat with
// operation = write stores cell_solid into the map cell (cell_col, cell_row) and gives
// no result. A beat with operation = resolve takes the sprite top-left (pos_x, pos_y,
// 4 fraction bits), tests its four corners against the map and pushes the sprite out
// of every solid corner tile, in corner order. The result beat on the output channel
// (out_valid / out_stall) carries new_x, new_y, saturated to 18 bits, and collided.
// The configuration channel (cfg_valid / cfg_ready) sets map_width and map_height
// and is always ready; it must be written only while the block is idle (not checked).
// Throughput: one item per clock cycle unless out_stall holds back a waiting result;
// every stage advances together. A resolve beat passes the input register, map read,
// four push stages (one per corner) and the output register, in that order.
// The four dependent pushes set the depth; the map is a 64 x 64 bit store with one
// write port and two row read ports, so both corner rows are read in the same cycle.
// Reset: the whole map reads empty at once (each row has a valid bit, and a row
// is filled on its first write), map_width and map_height return to 64, no beat
// is in flight.
// Stall: while out_stall holds back a waiting result, the whole pipeline holds and
// in_stall is raised; nothing is dropped or repeated.
`include "tile_map_collision_resolver_macros.svh"
module tile_map_collision_resolver (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               operation,
	input  logic [5:0]         cell_col,
	input  logic [5:0]         cell_row,
	input  logic               cell_solid,
	input  logic signed [17:0] pos_x,
	input  logic signed [17:0] pos_y,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [17:0] new_x,
	output logic signed [17:0] new_y,
	output logic               collided,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [6:0]         cfg_data
);
	logic            en;
	logic [6:0]      width_q, height_q, col_bound, row_bound;
	tmcr_pkg::pipe_t lk, p1, p2, p3, p4;
	logic signed [20:0] sx, sy;

	// advance everything unless a finished result is being held back
	assign en        = !(out_valid && out_stall);
	assign in_stall  = !en;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= tmcr_pkg::MaxCols;
			height_q <= tmcr_pkg::MaxRows;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				tmcr_pkg::REG_MAP_WIDTH:  width_q  <= cfg_data;
				tmcr_pkg::REG_MAP_HEIGHT: height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// clip the bounds to the store size
	assign col_bound = (width_q  > tmcr_pkg::MaxCols) ? tmcr_pkg::MaxCols : width_q;
	assign row_bound = (height_q > tmcr_pkg::MaxRows) ? tmcr_pkg::MaxRows : height_q;

	tmcr_lookup u_lookup (
		.clk, .arst_n, .en, .in_valid, .operation, .cell_col, .cell_row, .cell_solid,
		.pos_x, .pos_y, .col_bound, .row_bound, .out(lk)
	);

	tmcr_push_stage u_push0 (.clk, .arst_n, .en, .in(lk), .out(p1));
	tmcr_push_stage u_push1 (.clk, .arst_n, .en, .in(p1), .out(p2));
	tmcr_push_stage u_push2 (.clk, .arst_n, .en, .in(p2), .out(p3));
	tmcr_push_stage u_push3 (.clk, .arst_n, .en, .in(p3), .out(p4));

	// saturate to the 18-bit output range
	assign sx = p4.px;
	assign sy = p4.py;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= p4.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			collided <= p4.any;
			if (sx < -21'sd131072) begin
				new_x <= -18'sd131072;
			end else if (sx > 21'sd131071) begin
				new_x <= 18'sd131071;
			end else begin
				new_x <= sx[17:0];
			end
			if (sy < -21'sd131072) begin
				new_y <= -18'sd131072;
			end else if (sy > 21'sd131071) begin
				new_y <= 18'sd131071;
			end else begin
				new_y <= sy[17:0];
			end
		end
	end

	`TMCR_ASSERT_NOW(a_hold_input, out_valid && out_stall, in_stall)
	`TMCR_ASSERT_NOW(a_any_matches_hits, lk.vld && (lk.hit != 4'd0), lk.any)
	`TMCR_ASSERT_NEXT(a_width_write, cfg_valid && (cfg_index == tmcr_pkg::REG_MAP_WIDTH), width_q == $past(cfg_data))
	`TMCR_ASSERT_NOW(a_hits_drained, p4.vld, p4.hit == 4'd0)
endmodule
